### sv/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the Morse stream decoder
// Table and token sizes, operation codes, characters and the handshake
// structures that pass between the cells, the output queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int TABLE_ENTRIES  = 64;
    localparam int MAX_CODE_BYTES = 6;

    localparam int CODE_W       = MAX_CODE_BYTES * 8;
    localparam int ENTRY_CODE_W = 48;
    localparam int EXT_W        = (CODE_W > ENTRY_CODE_W) ? CODE_W : ENTRY_CODE_W;
    localparam int TABLE_INDEX_W = 6;
    localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int POS_W        = (IDX_W > TABLE_INDEX_W) ? IDX_W : TABLE_INDEX_W;
    localparam int LEN_W        = $clog2(MAX_CODE_BYTES + 2);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_BYTES);
    localparam logic [LEN_W-1:0] LEN_OVF = LEN_W'(MAX_CODE_BYTES + 1);

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STREAM = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } ctrl_state_t;

    typedef struct packed {
        logic                     en;
        logic [POS_W-1:0]         index;
        logic [7:0]               ch;
        logic [CODE_W-1:0]        code;
    } load_t;

    typedef struct packed {
        logic       active;
        logic       found;
        logic [7:0] ch;
    } search_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    e0;
        result_t    e1;
    } push_t;

    function automatic logic [CODE_W-1:0] fit_code(input logic [ENTRY_CODE_W-1:0] c);
        logic [EXT_W-1:0] wide;
        wide = EXT_W'(c);
        return wide[CODE_W-1:0];
    endfunction

    // Keeps the bytes above the first zero byte and clears the rest.
    function automatic logic [CODE_W-1:0] string_part(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] kept;
        logic              stop;
        logic [7:0]        b;
        kept = '0;
        stop = 1'b0;
        for (int i = 0; i < MAX_CODE_BYTES; i++)
        begin
            b = v[(MAX_CODE_BYTES - 1 - i) * 8 +: 8];
            if (b == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                kept[(MAX_CODE_BYTES - 1 - i) * 8 +: 8] = b;
            end
        end
        return kept;
    endfunction

endpackage

`default_nettype wire

### sv/msd_if.sv
// ----------------------------------------------------------------------------
// msd_if: stream channels of the Morse stream decoder
// Input items and result items, each with valid, ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface msd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [5:0]  table_index;
    logic [7:0]  entry_char;
    logic [47:0] entry_code;

    modport source (output valid, op, data_byte, table_index, entry_char, entry_code,
                    input ready);
    modport sink (input valid, op, data_byte, table_index, entry_char, entry_code,
                  output ready);
endinterface

interface msd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, out_char, last, input ready);
    modport sink (input valid, out_char, last, output ready);
endinterface

`default_nettype wire

### sv/morse_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// morse_stream_decoder_top: Morse token stream decoder with loadable table
// Builds tokens from stream bytes, looks them up in a row of table cells,
// and emits characters, spaces and newlines through a small result queue.
//
//   channel  role  payload
//   item     sink  op, data_byte, table_index, entry_char, entry_code
//   result   src   out_char, last
//
// Loads and stream bytes that end no token start no search.
// A token end starts a search, the trip through the registered cell row.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// Item ready drops while a search runs or the result queue has under two
// free slots, so a stalled result side holds the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_stream_decoder_top (
    input  wire logic clk,
    input  wire logic rst_n,
    msd_in_if.sink    item,
    msd_out_if.source result
);
    import msd_pkg::*;

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [CODE_W-1:0] token_reg;
    logic [CODE_W-1:0] token_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [1:0]        run_reg;
    logic [1:0]        run_next;
    logic [CODE_W-1:0] key_reg;
    logic [CODE_W-1:0] key_next;
    logic              tail_reg;
    logic              tail_next;
    logic              launch_reg;

    logic    acc;
    logic    is_space;
    logic    tok_ok;
    logic    need_search;
    logic    room;
    push_t   push;
    load_t   load;
    search_t links [TABLE_ENTRIES + 1];
    search_t chain_out;

    assign acc         = item.valid && item.ready;
    assign is_space    = (item.data_byte == CHAR_SPACE);
    assign tok_ok      = (len_reg != '0) && (len_reg <= LEN_MAX);
    assign need_search = acc && tok_ok
                         && ((item.op == OP_STREAM && is_space) || item.op == OP_END);
    assign chain_out   = links[TABLE_ENTRIES];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (need_search)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (chain_out.active)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item.ready = (state_reg == S_IDLE) && room;
    end

    always_comb
    begin
        load.en    = acc && (item.op == OP_LOAD);
        load.index = POS_W'(item.table_index);
        load.ch    = item.entry_char;
        load.code  = fit_code(item.entry_code);
    end

    always_comb
    begin
        token_next = token_reg;
        len_next   = len_reg;
        run_next   = run_reg;
        key_next   = key_reg;
        tail_next  = tail_reg;
        push       = '0;
        if (acc)
        begin
            if (need_search)
            begin
                key_next  = string_part(token_reg);
                tail_next = (item.op == OP_END);
            end
            unique case (item.op)
                OP_STREAM:
                begin
                    if (is_space)
                    begin
                        token_next = '0;
                        len_next   = '0;
                        if (run_reg == 2'd3)
                        begin
                            push.n  = 2'd2;
                            push.e0 = '{ch: CHAR_NEWLINE, last: 1'b0};
                            push.e1 = '{ch: CHAR_NEWLINE, last: 1'b1};
                            run_next = 2'd0;
                        end
                        else
                        begin
                            run_next = 2'(run_reg + 2'd1);
                        end
                    end
                    else
                    begin
                        if (run_reg == 2'd2)
                        begin
                            push.n  = 2'd1;
                            push.e0 = '{ch: CHAR_SPACE, last: 1'b1};
                        end
                        else if (run_reg == 2'd3)
                        begin
                            push.n  = 2'd1;
                            push.e0 = '{ch: CHAR_NEWLINE, last: 1'b1};
                        end
                        run_next = 2'd0;
                        if (len_reg < LEN_MAX)
                        begin
                            for (int k = 0; k < MAX_CODE_BYTES; k++)
                            begin
                                if (len_reg == LEN_W'(k))
                                begin
                                    token_next[(MAX_CODE_BYTES - 1 - k) * 8 +: 8] =
                                        item.data_byte;
                                end
                            end
                            len_next = LEN_W'(len_reg + LEN_W'(1));
                        end
                        else
                        begin
                            len_next = LEN_OVF;
                        end
                    end
                end
                OP_END:
                begin
                    token_next = '0;
                    len_next   = '0;
                    run_next   = 2'd0;
                    if (!tok_ok)
                    begin
                        if (run_reg == 2'd2)
                        begin
                            push.n  = 2'd2;
                            push.e0 = '{ch: CHAR_SPACE, last: 1'b0};
                            push.e1 = '{ch: CHAR_NEWLINE, last: 1'b1};
                        end
                        else if (run_reg == 2'd3)
                        begin
                            push.n  = 2'd2;
                            push.e0 = '{ch: CHAR_NEWLINE, last: 1'b0};
                            push.e1 = '{ch: CHAR_NEWLINE, last: 1'b1};
                        end
                        else
                        begin
                            push.n  = 2'd1;
                            push.e0 = '{ch: CHAR_NEWLINE, last: 1'b1};
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (chain_out.active)
        begin
            if (chain_out.found)
            begin
                push.e0 = '{ch: chain_out.ch, last: !tail_reg};
                push.e1 = '{ch: CHAR_NEWLINE, last: 1'b1};
                push.n  = tail_reg ? 2'd2 : 2'd1;
            end
            else if (tail_reg)
            begin
                push.n  = 2'd1;
                push.e0 = '{ch: CHAR_NEWLINE, last: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            token_reg  <= '0;
            len_reg    <= '0;
            run_reg    <= 2'd0;
            tail_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            token_reg  <= token_next;
            len_reg    <= len_next;
            run_reg    <= run_next;
            tail_reg   <= tail_next;
            launch_reg <= need_search;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_comb
    begin
        links[0]        = '0;
        links[0].active = launch_reg;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        msd_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .pos   (POS_W'(g)),
            .load  (load),
            .key   (key_reg),
            .prev  (links[g]),
            .next  (links[g + 1])
        );
    end

    msd_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

    a_launch_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> state_reg == S_SEARCH)
        else $error("search launched outside a search");

    a_result_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.active |-> state_reg == S_SEARCH)
        else $error("cell row result with no search in flight");

    a_token_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
        need_search |=> (state_reg == S_SEARCH) && launch_reg)
        else $error("token end did not start a search");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> state_reg == S_IDLE)
        else $error("item ready during a search");

endmodule

`default_nettype wire

### sv/msd_cell.sv
// ----------------------------------------------------------------------------
// msd_cell: one table entry of the decoder
// Holds a character and its code; passes the search flag and character on
// to the next cell each cycle, taking the match if none was found before.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [msd_pkg::POS_W-1:0]   pos,
    input  wire msd_pkg::load_t              load,
    input  wire logic [msd_pkg::CODE_W-1:0]  key,
    input  wire msd_pkg::search_t            prev,
    output msd_pkg::search_t                 next
);
    import msd_pkg::*;

    logic              valid_reg;
    logic [7:0]        ch_reg;
    logic [CODE_W-1:0] code_reg;
    search_t           next_reg;
    search_t           next_next;
    logic              hit;

    assign hit = prev.active && !prev.found && valid_reg && (code_reg == key);

    always_comb
    begin
        next_next = prev;
        if (hit)
        begin
            next_next.found = 1'b1;
            next_next.ch    = ch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            next_reg  <= '0;
        end
        else
        begin
            if (load.en && load.index == pos)
            begin
                valid_reg <= 1'b1;
            end
            next_reg <= next_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.en && load.index == pos)
        begin
            ch_reg   <= load.ch;
            code_reg <= string_part(load.code);
        end
    end

    assign next = next_reg;

endmodule

`default_nettype wire

### sv/msd_out_fifo.sv
// ----------------------------------------------------------------------------
// msd_out_fifo: result queue of the decoder
// Takes up to two results per cycle and delivers one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_out_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire msd_pkg::push_t push,
    output logic                room,
    msd_out_if.source           result
);
    import msd_pkg::*;

    result_t              mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_reg;
    logic [OUT_PTR_W-1:0] wr_next;
    logic [OUT_PTR_W-1:0] rd_reg;
    logic [OUT_PTR_W-1:0] rd_next;
    logic [OUT_CNT_W-1:0] cnt_reg;
    logic [OUT_CNT_W-1:0] cnt_next;
    logic                 pop;

    assign pop             = result.valid && result.ready;
    assign result.valid    = (cnt_reg != '0);
    assign result.out_char = mem_reg[rd_reg].ch;
    assign result.last     = mem_reg[rd_reg].last;
    assign room            = (cnt_reg <= OUT_CNT_W'(OUT_DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + OUT_PTR_W'(push.n);
        rd_next  = rd_reg + OUT_PTR_W'(pop);
        cnt_next = cnt_reg + OUT_CNT_W'(push.n) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_reg] <= push.e0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[OUT_PTR_W'(wr_reg + OUT_PTR_W'(1))] <= push.e1;
        end
    end

endmodule

`default_nettype wire
